// File: src/sdt_pkg.sv
// Shared types and constants for the sparkle decay timer.
package sdt_pkg;

  // Serial arithmetic: every multiply and divide takes this many steps.
  localparam int STEPS   = 16;
  localparam int STEP_W  = 4;
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(STEPS - 1);

  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 16;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int DIV_N_W = 32;
  localparam int DIV_D_W = 16;

  // Configuration register indexes.
  typedef logic [2:0] cfg_idx_t;
  localparam cfg_idx_t CFG_DECAY_MS        = 3'd0;
  localparam cfg_idx_t CFG_MAX_ACCEL       = 3'd1;
  localparam cfg_idx_t CFG_MAX_INTERVAL_MS = 3'd2;
  localparam cfg_idx_t CFG_PIXEL_COUNT     = 3'd3;
  localparam cfg_idx_t CFG_FLASH_COLOR     = 3'd4;
  localparam cfg_idx_t CFG_FLASH_MS        = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_DIV1,
    ST_MUL2,
    ST_MUL3,
    ST_DIV2,
    ST_DONE
  } sdt_state_t;

endpackage

// File: src/accel_peak_decay_sparkle_timer.sv
// Top level of the acceleration peak-decay sparkle timer.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+-----------------------------------------
//   in_     | input     | in_valid / in_stall   | now_ms, accel, rand_interval, rand_pixel
//   out_    | output    | out_valid / out_stall | flash, pixel_index, color_out, hold_ms,
//           |           |                       | decayed_level
//   cfg_    | input     | cfg_we (no wait)      | cfg_index, cfg_data
//
// One transaction at a time. Each multiply or divide runs on the serial multiplier or
// divider at one bit per cycle. A sample that fires no new wait draw runs one multiply
// and one divide; a sample that fires a flash with a nonzero clamp runs three more
// serial operations.
// Reset is synchronous, active low, and restores register defaults and zero state.
// The output register frees the input side: a new transaction is taken while a
// finished result still waits under out_stall; only the final load waits for it.
module accel_peak_decay_sparkle_timer import sdt_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [15:0]        in_now_ms,
  input  logic signed [15:0] in_accel,
  input  logic [15:0]        in_rand_interval,
  input  logic [7:0]         in_rand_pixel,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_flash,
  output logic [7:0]         out_pixel_index,
  output logic [23:0]        out_color_out,
  output logic [7:0]         out_hold_ms,
  output logic [14:0]        out_decayed_level,
  // configuration
  input  logic               cfg_we,
  input  cfg_idx_t           cfg_index,
  input  logic [23:0]        cfg_data
);

  sdt_state_t state_r, state_nxt;

  // configuration registers
  logic [15:0] decay_ms_r;
  logic [14:0] max_accel_r;
  logic [15:0] max_interval_r;
  logic [7:0]  pixel_count_r;
  logic [23:0] flash_color_r;
  logic [7:0]  flash_ms_r;

  // timer state
  logic [14:0] peak_level_r;
  logic [15:0] peak_time_r;
  logic [15:0] last_flash_r;
  logic [15:0] wait_r;

  // captured sample and intermediate results
  logic [15:0]        now_r;
  logic signed [15:0] accel_r;
  logic [15:0]        rint_r;
  logic [7:0]         rpix_r;
  logic [14:0]        mdiff_r;
  logic [14:0]        decayed_r;
  logic [7:0]         pix_r;
  logic               fire_r;

  // result register
  logic        out_valid_r;
  logic        out_flash_r;
  logic [7:0]  out_pixel_r;
  logic [23:0] out_color_r;
  logic [7:0]  out_hold_r;
  logic [14:0] out_decayed_r;

  // serial unit ports
  logic               mul_start;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_prod;
  logic               mul_done;
  logic               div_start;
  logic [DIV_N_W-1:0] div_dividend;
  logic [DIV_D_W-1:0] div_divisor;
  logic [DIV_D_W-1:0] div_quo;
  logic               div_done;
  logic               out_load;

  // combinational datapath
  logic [15:0] elapsed;
  logic [15:0] e_cap;
  logic [15:0] decay_left;
  logic [14:0] decayed;
  logic [16:0] acc_ext;
  logic [16:0] mag_full;
  logic        clamp;
  logic [14:0] mag;
  logic        take_peak;
  logic [15:0] wait_eff;
  logic [15:0] since_flash;
  logic        fire;
  logic        draw;
  logic [14:0] dcap;
  logic [14:0] mdiff;
  logic [15:0] pix_prod;

  sdt_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .prod  (mul_prod),
    .done  (mul_done)
  );

  sdt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quo      (div_quo),
    .done     (div_done)
  );

  // Time left on the decay ramp, taken from the incoming sample.
  assign elapsed    = in_now_ms - peak_time_r;
  assign e_cap      = (elapsed < decay_ms_r) ? elapsed : decay_ms_r;
  assign decay_left = decay_ms_r - e_cap;

  // Decayed peak; a zero decay time means the peak is already gone.
  assign decayed = (decay_ms_r == 16'd0) ? 15'd0 : div_quo[14:0];

  // |accel| in 17 bits so that the most negative sample stays exact.
  assign acc_ext  = {accel_r[15], accel_r};
  assign mag_full = accel_r[15] ? (17'd0 - acc_ext) : acc_ext;
  assign clamp    = mag_full >= {2'b00, max_accel_r};
  assign mag      = clamp ? max_accel_r : mag_full[14:0];
  assign take_peak = mag >= decayed;

  // A clamped sample zeroes the wait before the flash test.
  assign wait_eff    = clamp ? 16'd0 : wait_r;
  assign since_flash = now_r - last_flash_r;
  assign fire        = since_flash > wait_eff;
  assign draw        = fire && (max_accel_r != 15'd0);

  assign dcap  = (decayed < max_accel_r) ? decayed : max_accel_r;
  assign mdiff = max_accel_r - dcap;

  assign pix_prod = {8'd0, rpix_r} * {8'd0, pixel_count_r};

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_MUL1;
      ST_MUL1: if (mul_done) state_nxt = ST_DIV1;
      ST_DIV1: begin
        if (div_done) state_nxt = draw ? ST_MUL2 : ST_DONE;
      end
      ST_MUL2: if (mul_done) state_nxt = ST_MUL3;
      ST_MUL3: if (mul_done) state_nxt = ST_DIV2;
      ST_DIV2: if (div_done) state_nxt = ST_DONE;
      ST_DONE: if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs: start strobes and operand selection for the serial units.
  always_comb begin
    in_stall     = 1'b1;
    mul_start    = 1'b0;
    mul_a        = '0;
    mul_b        = '0;
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    out_load     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        // peak * time left on the ramp
        in_stall  = 1'b0;
        mul_start = in_valid;
        mul_a     = {16'd0, decay_left};
        mul_b     = {1'b0, peak_level_r};
      end
      ST_MUL1: begin
        div_start    = mul_done;
        div_dividend = mul_prod[31:0];
        div_divisor  = decay_ms_r;
      end
      ST_DIV1: begin
        // rand_interval * max_interval
        mul_start = div_done && draw;
        mul_a     = {16'd0, max_interval_r};
        mul_b     = rint_r;
      end
      ST_MUL2: begin
        // ... * (max_accel - capped decayed)
        mul_start = mul_done;
        mul_a     = mul_prod[31:0];
        mul_b     = {1'b0, mdiff_r};
      end
      ST_MUL3: begin
        // drop the low 16 bits first; the floor of the quotient is the same
        div_start    = mul_done;
        div_dividend = mul_prod[47:16];
        div_divisor  = {1'b0, max_accel_r};
      end
      ST_DIV2: begin
      end
      ST_DONE: out_load = !out_valid_r || !out_stall;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decay_ms_r     <= 16'd1000;
      max_accel_r    <= 15'd8192;
      max_interval_r <= 16'd500;
      pixel_count_r  <= 8'd60;
      flash_color_r  <= 24'hFFFFFF;
      flash_ms_r     <= 8'd10;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DECAY_MS:        decay_ms_r     <= cfg_data[15:0];
        CFG_MAX_ACCEL:       max_accel_r    <= cfg_data[14:0];
        CFG_MAX_INTERVAL_MS: max_interval_r <= cfg_data[15:0];
        CFG_PIXEL_COUNT:     pixel_count_r  <= cfg_data[7:0];
        CFG_FLASH_COLOR:     flash_color_r  <= cfg_data;
        CFG_FLASH_MS:        flash_ms_r     <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  // Peak, flash time and wait updates.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_level_r <= '0;
      peak_time_r  <= '0;
      last_flash_r <= '0;
      wait_r       <= '0;
    end else begin
      if (state_r == ST_DIV1 && div_done) begin
        if (take_peak) begin
          peak_level_r <= mag;
          peak_time_r  <= now_r;
        end
        if (fire) last_flash_r <= now_r;
        // a drawn wait overwrites this later
        if (clamp || fire) wait_r <= '0;
      end
      if (state_r == ST_DIV2 && div_done) wait_r <= div_quo;
    end
  end

  // Hold the sample and intermediate values for the rest of the transaction.
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      now_r   <= in_now_ms;
      accel_r <= in_accel;
      rint_r  <= in_rand_interval;
      rpix_r  <= in_rand_pixel;
    end
    if (state_r == ST_DIV1 && div_done) begin
      decayed_r <= decayed;
      fire_r    <= fire;
      mdiff_r   <= mdiff;
      pix_r     <= pix_prod[15:8];
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_flash_r   <= fire_r;
      out_pixel_r   <= fire_r ? pix_r : 8'd0;
      out_color_r   <= fire_r ? flash_color_r : 24'd0;
      out_hold_r    <= fire_r ? flash_ms_r : 8'd0;
      out_decayed_r <= decayed_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_flash         = out_flash_r;
  assign out_pixel_index   = out_pixel_r;
  assign out_color_out     = out_color_r;
  assign out_hold_ms       = out_hold_r;
  assign out_decayed_level = out_decayed_r;

  // An accepted transaction always starts with the ramp multiply.
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == ST_MUL1))
    else $error("accepted sample did not start the ramp multiply");

  // The two serial units are never launched in the same cycle.
  a_one_start: assert property (@(posedge clk) disable iff (!rst_n)
    !(mul_start && div_start))
    else $error("multiplier and divider started together");

  // The decayed peak never outgrows 15 bits.
  a_decay_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV1 && div_done) |-> (decay_ms_r == 16'd0 || div_quo[15] == 1'b0))
    else $error("decayed peak quotient overflow");

endmodule

// File: src/sdt_mul.sv
// Shift-add multiplier, one multiplier bit per cycle.
module sdt_mul import sdt_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [MUL_A_W-1:0] a,
  input  logic [MUL_B_W-1:0] b,
  output logic [MUL_P_W-1:0] prod,
  output logic               done
);

  logic [MUL_A_W-1:0] a_r;
  logic [MUL_A_W-1:0] hi_r;
  logic [MUL_B_W-1:0] lo_r;
  logic [STEP_W-1:0]  cnt_r;
  logic               busy_r;
  logic               done_r;
  logic [MUL_A_W:0]   sum;

  // Add the multiplicand when the low bit is set, then shift right.
  assign sum  = {1'b0, hi_r} + (lo_r[0] ? {1'b0, a_r} : '0);
  assign prod = {hi_r, lo_r};
  assign done = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + STEP_W'(1);
        if (cnt_r == STEP_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r  <= a;
      hi_r <= '0;
      lo_r <= b;
    end else if (busy_r) begin
      {hi_r, lo_r} <= {sum, lo_r[MUL_B_W-1:1]};
    end
  end

endmodule

// File: src/sdt_div.sv
// Restoring divider, one quotient bit per cycle; needs dividend[31:16] < divisor.
module sdt_div import sdt_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [DIV_N_W-1:0] dividend,
  input  logic [DIV_D_W-1:0] divisor,
  output logic [DIV_D_W-1:0] quo,
  output logic               done
);

  logic [DIV_D_W-1:0] rem_r;
  logic [DIV_D_W-1:0] q_r;
  logic [DIV_D_W-1:0] d_r;
  logic [STEP_W-1:0]  cnt_r;
  logic               busy_r;
  logic               done_r;
  logic [DIV_D_W:0]   trial;
  logic [DIV_D_W:0]   diff;
  logic               ge;
  logic [DIV_D_W-1:0] rem_nxt;

  // Bring down the next dividend bit and subtract if it fits.
  assign trial   = {rem_r, q_r[DIV_D_W-1]};
  assign ge      = trial >= {1'b0, d_r};
  assign diff    = trial - {1'b0, d_r};
  assign rem_nxt = ge ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
  assign quo     = q_r;
  assign done    = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + STEP_W'(1);
        if (cnt_r == STEP_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend[DIV_N_W-1:DIV_D_W];
      q_r   <= dividend[DIV_D_W-1:0];
      d_r   <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= {q_r[DIV_D_W-2:0], ge};
    end
  end

endmodule

// File: verif/tb.sv
// Self-checking testbench for the acceleration peak-decay sparkle timer.
module tb;
  import sdt_pkg::*;

  // One result transaction, in port order.
  typedef struct packed {
    logic        flash;
    logic [7:0]  pixel;
    logic [23:0] color;
    logic [7:0]  hold;
    logic [14:0] level;
  } flash_result_t;

  // Scoreboard: mirrors the registers and the peak/flash state, predicts one
  // result per accepted sample and checks results in order.
  class sparkle_checker;
    logic [15:0] decay_ms;
    logic [14:0] max_accel;
    logic [15:0] max_interval_ms;
    logic [7:0]  pixel_count;
    logic [23:0] flash_color;
    logic [7:0]  flash_ms;
    logic [14:0] peak_level;
    logic [15:0] peak_time;
    logic [15:0] last_flash_time;
    logic [15:0] wait_ms;
    flash_result_t expected_flashes[$];
    int errors;

    function new();
      decay_ms        = 16'd1000;
      max_accel       = 15'd8192;
      max_interval_ms = 16'd500;
      pixel_count     = 8'd60;
      flash_color     = 24'hFFFFFF;
      flash_ms        = 8'd10;
      peak_level      = '0;
      peak_time       = '0;
      last_flash_time = '0;
      wait_ms         = '0;
      errors          = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [23:0] val);
      unique case (idx)
        CFG_DECAY_MS:        decay_ms        = val[15:0];
        CFG_MAX_ACCEL:       max_accel       = val[14:0];
        CFG_MAX_INTERVAL_MS: max_interval_ms = val[15:0];
        CFG_PIXEL_COUNT:     pixel_count     = val[7:0];
        CFG_FLASH_COLOR:     flash_color     = val;
        CFG_FLASH_MS:        flash_ms        = val[7:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_flashes.size();
    endfunction

    // Advance the peak and flash state by one sample and queue the result.
    function void take_sample(logic [15:0] now, logic signed [15:0] accel,
                              logic [15:0] rand_interval, logic [7:0] rand_pixel);
      logic [15:0]   elapsed;
      logic [15:0]   since_flash;
      logic [15:0]   used;
      logic [16:0]   mag;
      logic [14:0]   decayed;
      logic [14:0]   capped;
      flash_result_t r;
      elapsed = now - peak_time;
      if (decay_ms == 16'd0) begin
        decayed = '0;
      end else begin
        used    = (elapsed < decay_ms) ? elapsed : decay_ms;
        decayed = 15'((64'(peak_level) * 64'(decay_ms - used)) / 64'(decay_ms));
      end
      mag = accel[15] ? 17'h10000 - {1'b0, accel} : {1'b0, accel};
      // A sample at the clamp cancels the pending wait.
      if (mag >= {2'b0, max_accel}) begin
        mag     = {2'b0, max_accel};
        wait_ms = '0;
      end
      if (mag >= {2'b0, decayed}) begin
        peak_level = mag[14:0];
        peak_time  = now;
      end
      r       = '0;
      r.level = decayed;
      since_flash = now - last_flash_time;
      if (since_flash > wait_ms) begin
        last_flash_time = now;
        if (max_accel == 15'd0) begin
          wait_ms = '0;
        end else begin
          capped  = (decayed < max_accel) ? decayed : max_accel;
          wait_ms = 16'(((64'(rand_interval) * 64'(max_interval_ms)
                        * 64'(max_accel - capped)) / 64'(max_accel)) >> 16);
        end
        r.flash = 1'b1;
        r.pixel = 8'((16'(rand_pixel) * 16'(pixel_count)) >> 8);
        r.color = flash_color;
        r.hold  = flash_ms;
      end
      expected_flashes.push_back(r);
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("ERROR @%0t: %s", $time, msg);
    endtask

    task check_result(flash_result_t got);
      flash_result_t want;
      if (expected_flashes.size() == 0) begin
        report_mismatch("result with no sample waiting");
        return;
      end
      want = expected_flashes.pop_front();
      if (got.flash !== want.flash)
        report_mismatch($sformatf("flash got %0d want %0d", got.flash, want.flash));
      if (got.pixel !== want.pixel)
        report_mismatch($sformatf("pixel_index got %0d want %0d", got.pixel, want.pixel));
      if (got.color !== want.color)
        report_mismatch($sformatf("color_out got %h want %h", got.color, want.color));
      if (got.hold !== want.hold)
        report_mismatch($sformatf("hold_ms got %0d want %0d", got.hold, want.hold));
      if (got.level !== want.level)
        report_mismatch($sformatf("decayed_level got %0d want %0d", got.level, want.level));
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [15:0]        in_now_ms = '0;
  logic signed [15:0] in_accel = '0;
  logic [15:0]        in_rand_interval = '0;
  logic [7:0]         in_rand_pixel = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_flash;
  logic [7:0]         out_pixel_index;
  logic [23:0]        out_color_out;
  logic [7:0]         out_hold_ms;
  logic [14:0]        out_decayed_level;
  logic               cfg_we = 1'b0;
  cfg_idx_t           cfg_index = CFG_DECAY_MS;
  logic [23:0]        cfg_data = '0;

  sparkle_checker sb = new();

  // Idle control: percent chance of an input gap before each sample and of a stall burst.
  int          gap_pct = 15;
  int          stall_pct = 15;
  int          stall_left = 0;
  logic [15:0] clock_ms = '0;

  accel_peak_decay_sparkle_timer u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_now_ms         (in_now_ms),
    .in_accel          (in_accel),
    .in_rand_interval  (in_rand_interval),
    .in_rand_pixel     (in_rand_pixel),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_flash         (out_flash),
    .out_pixel_index   (out_pixel_index),
    .out_color_out     (out_color_out),
    .out_hold_ms       (out_hold_ms),
    .out_decayed_level (out_decayed_level),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Hold out_stall in random bursts; drop it entirely when stall_pct is zero.
  always @(negedge clk) begin
    if (stall_pct == 0) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      stall_left = $urandom_range(0, 10);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Sample both channels at the rising edge. Check the result first so a
  // transaction taken on the same edge queues behind older expectations.
  always @(posedge clk) begin : monitor
    flash_result_t seen;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        seen = {out_flash, out_pixel_index, out_color_out, out_hold_ms, out_decayed_level};
        sb.check_result(seen);
      end
      if (in_valid && !in_stall)
        sb.take_sample(in_now_ms, in_accel, in_rand_interval, in_rand_pixel);
    end
  end

  // Present one sample from a falling edge and hold it until accepted.
  // Leave in_valid high on return so back-to-back samples stay contiguous.
  task send_sample(input logic [15:0] now, input logic signed [15:0] accel,
                   input logic [15:0] rand_interval, input logic [7:0] rand_pixel);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_now_ms        <= now;
    in_accel         <= accel;
    in_rand_interval <= rand_interval;
    in_rand_pixel    <= rand_pixel;
    clock_ms = now;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Drop valid and wait until every predicted result has come back.
  task settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task write_reg(input cfg_idx_t idx, input logic [23:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    sb.set_reg(idx, val);
    @(negedge clk);
  endtask

  task apply_cfg(input logic [15:0] decay, input logic [14:0] clamp,
                 input logic [15:0] max_wait, input logic [7:0] pixels,
                 input logic [23:0] color, input logic [7:0] on_ms);
    write_reg(CFG_DECAY_MS, 24'(decay));
    write_reg(CFG_MAX_ACCEL, 24'(clamp));
    write_reg(CFG_MAX_INTERVAL_MS, 24'(max_wait));
    write_reg(CFG_PIXEL_COUNT, 24'(pixels));
    write_reg(CFG_FLASH_COLOR, color);
    write_reg(CFG_FLASH_MS, 24'(on_ms));
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task random_cfg();
    apply_cfg(16'($urandom_range(1, 65535)), 15'($urandom_range(1, 32767)),
              16'($urandom), 8'($urandom_range(1, 255)), 24'($urandom), 8'($urandom));
  endtask

  // Random samples: time mostly moves forward in small steps so the decay
  // and wait windows actually get crossed; acceleration clusters around
  // zero and the clamp, with some full-range noise.
  task random_samples(input int count);
    logic [15:0] now;
    int          clamp;
    int          mag;
    int          a;
    for (int k = 0; k < count; k++) begin
      case ($urandom_range(0, 7))
        0:       now = clock_ms;
        1, 2, 3: now = clock_ms + 16'($urandom_range(0, 16));
        4, 5:    now = clock_ms + 16'($urandom_range(0, 300));
        6:       now = clock_ms + 16'($urandom_range(0, 4000));
        default: now = 16'($urandom);
      endcase
      clamp = int'(sb.max_accel);
      case ($urandom_range(0, 3))
        0:       mag = int'($urandom_range(0, 32768));
        1:       mag = int'($urandom_range(0, clamp));
        2:       mag = clamp + int'($urandom_range(0, 4)) - 2;
        default: mag = int'($urandom_range(0, clamp / 4));
      endcase
      if (mag < 0) mag = 0;
      a = $urandom_range(0, 1) ? -mag : mag;
      if (a > 32767) a = 32767;
      send_sample(now, 16'(a), 16'($urandom), 8'($urandom));
    end
  endtask

  task random_phase(input int count, input int gaps, input int stalls);
    gap_pct   = gaps;
    stall_pct = stalls;
    random_samples(count);
    settle();
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: first sample, full-scale both signs, the clamp edge,
    // a wait drawn large and then cancelled by a clamp hit, time wrap.
    send_sample(16'd0, 16'sd0, 16'h0000, 8'h00);
    send_sample(16'd1, 16'sd0, 16'hFFFF, 8'hFF);
    send_sample(16'd100, 16'sd32767, 16'h0000, 8'h00);
    send_sample(16'd101, 16'sh8000, 16'h8000, 8'h80);
    send_sample(16'd200, -16'sd1, 16'hFFFF, 8'h01);
    send_sample(16'd700, 16'sd8191, 16'hFFFF, 8'h7F);
    send_sample(16'd701, 16'sd8192, 16'h1234, 8'hFE);
    send_sample(16'd702, -16'sd8193, 16'hFFFF, 8'h3C);
    send_sample(16'd65535, 16'sd4096, 16'h00FF, 8'hC3);
    send_sample(16'd3, 16'sd0, 16'hFF00, 8'h55);
    send_sample(16'd1003, 16'sd1, 16'hAAAA, 8'hAA);
    settle();

    // Zero decay, zero clamp, zero pixel count, black, zero on time.
    apply_cfg(16'd0, 15'd0, 16'd65535, 8'd0, 24'h000000, 8'd0);
    send_sample(16'd10, 16'sd5000, 16'hFFFF, 8'hFF);
    send_sample(16'd20, -16'sd5000, 16'hFFFF, 8'hFF);
    send_sample(16'd20, 16'sd0, 16'h0001, 8'h10);
    send_sample(16'd30, 16'sd32767, 16'hFFFF, 8'h80);
    settle();

    // Upper extremes of every register.
    apply_cfg(16'd65535, 15'd32767, 16'd65535, 8'd255, 24'hFFFFFF, 8'd255);
    send_sample(16'd0, 16'sd32767, 16'hFFFF, 8'hFF);
    send_sample(16'd1, 16'sh8000, 16'hFFFF, 8'hFF);
    send_sample(16'd2, -16'sd32767, 16'h8001, 8'h01);
    send_sample(16'd40000, 16'sd0, 16'hFFFF, 8'hFF);
    send_sample(16'd40001, 16'sd1, 16'h0000, 8'h00);
    settle();

    // Random traffic under fixed and random settings, varying the idle mix.
    apply_cfg(16'd1000, 15'd8192, 16'd500, 8'd60, 24'hFFFFFF, 8'd10);
    random_phase(80, 15, 15);
    apply_cfg(16'd1, 15'd1, 16'd0, 8'd1, 24'h5A5A5A, 8'd1);
    random_phase(50, 30, 5);
    apply_cfg(16'd65535, 15'd32767, 16'd65535, 8'd255, 24'hA5A5A5, 8'd255);
    random_phase(50, 0, 30);
    apply_cfg(16'd0, 15'd0, 16'd1, 8'd0, 24'h0F0F0F, 8'd128);
    random_phase(40, 10, 10);
    for (int p = 0; p < 4; p++) begin
      random_cfg();
      random_phase(60, 5 * int'($urandom_range(0, 6)), 5 * int'($urandom_range(0, 6)));
    end

    // Last stretch runs at full rate with no idling on either side.
    random_cfg();
    random_phase(60, 0, 0);

    // Let any stray result show up before the verdict.
    repeat (200) @(posedge clk);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Hard stop far beyond the slowest legal run.
  initial begin
    #3200000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// File: files.f
src/sdt_pkg.sv
src/sdt_mul.sv
src/sdt_div.sv
src/accel_peak_decay_sparkle_timer.sv
verif/tb.sv
